### rtl/list_mode_record_decoder_assert.svh
// Assertion helpers for the list-mode record decoder checks.
`ifndef LIST_MODE_RECORD_DECODER_ASSERT_SVH
`define LIST_MODE_RECORD_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define LMRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list mode decoder: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define LMRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list mode decoder: next-cycle check failed");

`endif

### rtl/lmrd_pkg.sv
`default_nettype none

package lmrd_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_SUM   = 2'd1;
    localparam logic [1:0] KIND_QDC   = 2'd2;
    localparam logic [1:0] KIND_TRACE = 2'd3;

    // Header kind part of the status field.
    localparam logic [3:0] HDR_KIND_4     = 4'd1;
    localparam logic [3:0] HDR_KIND_8     = 4'd2;
    localparam logic [3:0] HDR_KIND_12    = 4'd4;
    localparam logic [3:0] HDR_KIND_OTHER = 4'd8;

    // Clock period register after reset, in picoseconds.
    localparam logic [13:0] PERIOD_RESET_PS = 14'd10000;

    // Framing phase of the word stream, one-hot.
    typedef enum logic [3:0] {
        PH_LEN   = 4'b0001,
        PH_VSN   = 4'b0010,
        PH_HDR   = 4'b0100,
        PH_TRACE = 4'b1000
    } t_phase;

    // One decoded record: the first result plus the count of pad pairs after it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [51:0] time_ps;
        logic [11:0] channel_id;
        logic [15:0] energy;
        logic [5:0]  status;
        logic [14:0] trace_len;
        logic [31:0] module_vsn;
        logic [12:0] item_index;
        logic [31:0] value;
        logic [14:0] sample_a;
        logic [14:0] sample_b;
        logic [1:0]  pad_pairs;
    } t_rec;

endpackage

`default_nettype wire

### rtl/lmrd_parser.sv
`default_nettype none

module lmrd_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Configuration
    input  wire logic          i_cfg_wr_en,
    input  wire logic [13:0]   i_cfg_wr_data,
    // Word stream
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [31:0]   i_data_word,
    input  wire logic          i_spill_start,
    // Decoded records
    output logic               o_rec_valid,
    input  wire logic          i_rec_ready,
    output lmrd_pkg::t_rec     o_rec
);

    // Header word positions with a fixed meaning.
    localparam logic [4:0] POS_ID     = 5'd0;
    localparam logic [4:0] POS_CLK_LO = 5'd1;
    localparam logic [4:0] POS_CLK_HI = 5'd2;
    localparam logic [4:0] POS_ENERGY = 5'd3;

    // Input register.
    logic        r_in_valid;
    logic [31:0] r_word;
    logic        r_start;

    // Decoder state.
    lmrd_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_mwl, n_mwl;
    logic [4:0]  r_hpos, n_hpos;
    logic [4:0]  r_hl, n_hl;
    logic [12:0] r_twl, n_twl;
    logic [13:0] r_ts, n_ts;
    logic [31:0] r_first, n_first;
    logic [31:0] r_clk_lo, n_clk_lo;
    logic [15:0] r_clk_hi, n_clk_hi;
    logic [31:0] r_vsn, n_vsn;
    logic [13:0] r_period;

    // Record register.
    logic           r_rec_valid;
    lmrd_pkg::t_rec r_rec, n_rec;
    logic           n_has;

    logic             adv;
    lmrd_pkg::t_phase e_phase;
    logic [31:0]      e_mwl;
    logic [4:0]       e_hpos;
    logic [12:0]      e_twl;
    logic [31:0]      mwl_dec;
    logic [4:0]       hl_cur;
    logic [4:0]       hl_field;
    logic [12:0]      twl_cur;
    logic [13:0]      lent;
    logic [13:0]      ts_new;
    logic [14:0]      padded;
    logic [61:0]      product;
    logic [12:0]      pair;
    logic [12:0]      pairs_total;
    logic [3:0]       hdr_kind;

    // The word moves on when the record slot is free or being emptied.
    assign adv        = r_in_valid && (!r_rec_valid || i_rec_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_word  <= i_data_word;
            r_start <= i_spill_start;
        end
    end

    // Clock period register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= lmrd_pkg::PERIOD_RESET_PS;
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    // Time stamp scaling, from the registered clock words.
    assign product = 62'({r_clk_hi, r_clk_lo}) * 62'(r_period);

    // Decode of one word against the framing state.
    always_comb begin
        // A spill start restarts module framing before the word is looked at.
        e_phase = r_start ? lmrd_pkg::PH_LEN : r_phase;
        e_mwl   = r_start ? 32'd0 : r_mwl;
        e_hpos  = r_start ? 5'd0 : r_hpos;
        e_twl   = r_start ? 13'd0 : r_twl;

        mwl_dec  = (e_mwl != 32'd0) ? e_mwl - 32'd1 : 32'd0;
        hl_field = r_word[16:12];
        lent     = r_word[29:16];
        ts_new   = {lent[13:1], 1'b0};
        padded   = ({1'b0, ts_new} + 15'd7) & ~15'd7;
        hl_cur   = r_hl;
        twl_cur  = e_twl;
        pair     = r_ts[13:1] - e_twl;
        pairs_total = r_ts[13:1];
        hdr_kind = lmrd_pkg::HDR_KIND_OTHER;

        n_phase  = e_phase;
        n_mwl    = e_mwl;
        n_hpos   = e_hpos;
        n_hl     = r_hl;
        n_twl    = e_twl;
        n_ts     = r_ts;
        n_first  = r_first;
        n_clk_lo = r_clk_lo;
        n_clk_hi = r_clk_hi;
        n_vsn    = r_vsn;

        n_rec            = '0;
        n_rec.module_vsn = r_vsn;
        n_has            = 1'b0;

        unique case (e_phase)
            lmrd_pkg::PH_LEN: begin
                n_mwl   = (r_word == 32'd0) ? 32'd0 : r_word - 32'd1;
                n_phase = lmrd_pkg::PH_VSN;
            end
            lmrd_pkg::PH_VSN: begin
                n_mwl   = mwl_dec;
                n_vsn   = r_word;
                n_phase = (mwl_dec == 32'd0) ? lmrd_pkg::PH_LEN : lmrd_pkg::PH_HDR;
            end
            lmrd_pkg::PH_HDR: begin
                n_mwl = mwl_dec;
                if (e_hpos == POS_ID) begin
                    hl_cur = (hl_field < 5'd4) ? 5'd4 : hl_field;
                end
                n_hl = hl_cur;

                // Header kind from the header length.
                if (hl_cur == 5'd4) begin
                    hdr_kind = lmrd_pkg::HDR_KIND_4;
                end else if (hl_cur == 5'd8) begin
                    hdr_kind = lmrd_pkg::HDR_KIND_8;
                end else if (hl_cur == 5'd12) begin
                    hdr_kind = lmrd_pkg::HDR_KIND_12;
                end

                case (e_hpos)
                    POS_ID:     n_first  = r_word;
                    POS_CLK_LO: n_clk_lo = r_word;
                    POS_CLK_HI: n_clk_hi = r_word[15:0];
                    POS_ENERGY: begin
                        twl_cur          = lent[13:1];
                        n_ts             = ts_new;
                        n_has            = 1'b1;
                        n_rec.kind       = lmrd_pkg::KIND_EVENT;
                        n_rec.time_ps    = product[51:0];
                        n_rec.channel_id = r_first[11:0];
                        n_rec.energy     = r_word[15:0];
                        n_rec.status     = {(lent != 14'd0), r_first[31], hdr_kind};
                        n_rec.trace_len  = padded;
                    end
                    default: begin
                        // Sum and QDC words past the fixed header.
                        if ((hl_cur == 5'd8 || hl_cur == 5'd16) && e_hpos < 5'd8) begin
                            n_has            = 1'b1;
                            n_rec.kind       = lmrd_pkg::KIND_SUM;
                            n_rec.item_index = 13'(e_hpos - 5'd4);
                            n_rec.value      = r_word;
                        end else if (hl_cur == 5'd12 && e_hpos < 5'd12) begin
                            n_has            = 1'b1;
                            n_rec.kind       = lmrd_pkg::KIND_QDC;
                            n_rec.item_index = 13'(e_hpos - 5'd4);
                            n_rec.value      = r_word;
                        end else if (hl_cur == 5'd16 && e_hpos < 5'd16) begin
                            n_has            = 1'b1;
                            n_rec.kind       = lmrd_pkg::KIND_QDC;
                            n_rec.item_index = 13'(e_hpos - 5'd8);
                            n_rec.value      = r_word;
                        end
                    end
                endcase

                // End of header: go to the trace or close the event.
                n_twl = twl_cur;
                if (({1'b0, e_hpos} + 6'd1) >= {1'b0, hl_cur}) begin
                    n_hpos = 5'd0;
                    if (twl_cur != 13'd0) begin
                        n_phase = lmrd_pkg::PH_TRACE;
                    end else begin
                        n_twl   = 13'd0;
                        n_phase = (mwl_dec == 32'd0) ? lmrd_pkg::PH_LEN : lmrd_pkg::PH_HDR;
                    end
                end else begin
                    n_hpos = e_hpos + 5'd1;
                end
            end
            lmrd_pkg::PH_TRACE: begin
                n_mwl            = mwl_dec;
                n_has            = 1'b1;
                n_rec.kind       = lmrd_pkg::KIND_TRACE;
                n_rec.item_index = pair;
                n_rec.sample_a   = r_word[14:0];
                n_rec.sample_b   = r_word[30:16];
                n_twl            = e_twl - 13'd1;
                if (n_twl == 13'd0) begin
                    // Pad pairs bring the pair count up to a multiple of four.
                    n_rec.pad_pairs = 2'd0 - pairs_total[1:0];
                    n_hpos  = 5'd0;
                    n_phase = (mwl_dec == 32'd0) ? lmrd_pkg::PH_LEN : lmrd_pkg::PH_HDR;
                end
            end
            default: begin
                n_phase = lmrd_pkg::PH_LEN;
            end
        endcase
    end

    // State and record registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lmrd_pkg::PH_LEN;
            r_mwl       <= 32'd0;
            r_hpos      <= 5'd0;
            r_hl        <= 5'd0;
            r_twl       <= 13'd0;
            r_ts        <= 14'd0;
            r_first     <= 32'd0;
            r_clk_lo    <= 32'd0;
            r_clk_hi    <= 16'd0;
            r_vsn       <= 32'd0;
            r_rec_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_phase     <= n_phase;
                r_mwl       <= n_mwl;
                r_hpos      <= n_hpos;
                r_hl        <= n_hl;
                r_twl       <= n_twl;
                r_ts        <= n_ts;
                r_first     <= n_first;
                r_clk_lo    <= n_clk_lo;
                r_clk_hi    <= n_clk_hi;
                r_vsn       <= n_vsn;
                r_rec_valid <= n_has;
            end else if (i_rec_ready) begin
                r_rec_valid <= 1'b0;
            end
        end
        if (adv && n_has) begin
            r_rec <= n_rec;
        end
    end

    assign o_rec_valid = r_rec_valid;
    assign o_rec       = r_rec;

endmodule

`default_nettype wire

### rtl/lmrd_expander.sv
`default_nettype none

module lmrd_expander (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // Decoded records
    input  wire logic          i_rec_valid,
    output logic               o_rec_ready,
    input  wire lmrd_pkg::t_rec i_rec,
    // Results
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_kind,
    output logic [51:0]        o_time_ps,
    output logic [11:0]        o_channel_id,
    output logic [15:0]        o_energy,
    output logic [5:0]         o_status,
    output logic [14:0]        o_trace_len,
    output logic [31:0]        o_module_vsn,
    output logic [12:0]        o_item_index,
    output logic [31:0]        o_value,
    output logic [14:0]        o_sample_a,
    output logic [14:0]        o_sample_b,
    output logic               o_last
);

    logic           r_valid;
    lmrd_pkg::t_rec r_rec;
    logic [1:0]     r_sub;
    logic           is_last;

    // The held record is done once its final result is taken.
    assign is_last     = (r_sub == r_rec.pad_pairs);
    assign o_rec_ready = !r_valid || (i_out_ready && is_last);

    // Result register: loads a record and steps through its pad pairs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else if (o_rec_ready) begin
            r_valid <= i_rec_valid;
            r_sub   <= 2'd0;
        end else if (i_out_ready) begin
            r_sub <= r_sub + 2'd1;
        end
        if (o_rec_ready && i_rec_valid) begin
            r_rec <= i_rec;
        end
    end

    // Pad pairs reuse the record with zero samples and following indexes.
    assign o_out_valid  = r_valid;
    assign o_kind       = r_rec.kind;
    assign o_time_ps    = r_rec.time_ps;
    assign o_channel_id = r_rec.channel_id;
    assign o_energy     = r_rec.energy;
    assign o_status     = r_rec.status;
    assign o_trace_len  = r_rec.trace_len;
    assign o_module_vsn = r_rec.module_vsn;
    assign o_item_index = r_rec.item_index + 13'(r_sub);
    assign o_value      = r_rec.value;
    assign o_sample_a   = (r_sub == 2'd0) ? r_rec.sample_a : 15'd0;
    assign o_sample_b   = (r_sub == 2'd0) ? r_rec.sample_b : 15'd0;
    assign o_last       = is_last;

endmodule

`default_nettype wire

### rtl/list_mode_record_decoder.sv
// Channel    | Direction | Handshake                  | Payload
// word in    | input     | i_in_valid / o_in_ready    | i_data_word, i_spill_start
// result out | output    | o_out_valid / i_out_ready  | o_kind ... o_last
// config     | input     | i_cfg_wr_en                | i_cfg_wr_data (clock period, ps)
//
// One word is taken per cycle while results drain one per cycle. A word enters the
// input register, its first result the record and then the result register; the last
// trace word of an event gives up to four results, one per cycle at the output. The
// result register sets the rate: a word that gives n results holds it until the last
// is taken. Reset (synchronous, active low) expects a module length word; period is
// 10000 ps. A stall at the output holds the result and backs up through all registers.
`default_nettype none

module list_mode_record_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [13:0]   i_cfg_wr_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [31:0]   i_data_word,
    input  wire logic          i_spill_start,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_kind,
    output logic [51:0]        o_time_ps,
    output logic [11:0]        o_channel_id,
    output logic [15:0]        o_energy,
    output logic [5:0]         o_status,
    output logic [14:0]        o_trace_len,
    output logic [31:0]        o_module_vsn,
    output logic [12:0]        o_item_index,
    output logic [31:0]        o_value,
    output logic [14:0]        o_sample_a,
    output logic [14:0]        o_sample_b,
    output logic               o_last
);

    logic           rec_valid;
    logic           rec_ready;
    lmrd_pkg::t_rec rec;

    // Framing and header decode.
    lmrd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_word   (i_data_word),
        .i_spill_start (i_spill_start),
        .o_rec_valid   (rec_valid),
        .i_rec_ready   (rec_ready),
        .o_rec         (rec)
    );

    // Result register and pad pair expansion.
    lmrd_expander u_expander (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (rec_valid),
        .o_rec_ready  (rec_ready),
        .i_rec        (rec),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_time_ps    (o_time_ps),
        .o_channel_id (o_channel_id),
        .o_energy     (o_energy),
        .o_status     (o_status),
        .o_trace_len  (o_trace_len),
        .o_module_vsn (o_module_vsn),
        .o_item_index (o_item_index),
        .o_value      (o_value),
        .o_sample_a   (o_sample_a),
        .o_sample_b   (o_sample_b),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### rtl/lmrd_checker.sv
`default_nettype none

`include "list_mode_record_decoder_assert.svh"

module lmrd_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         o_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [1:0]   o_kind,
    input  wire logic [51:0]  o_time_ps,
    input  wire logic [5:0]   o_status,
    input  wire logic [14:0]  o_trace_len,
    input  wire logic [12:0]  o_item_index,
    input  wire logic [31:0]  o_value,
    input  wire logic [14:0]  o_sample_a,
    input  wire logic [14:0]  o_sample_b,
    input  wire logic         o_last
);

    // A stalled result keeps its kind, index and end marker.
    `LMRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_kind) && $stable(o_item_index) && $stable(o_last))

    // An event reports exactly one header kind, with a zero index and value.
    `LMRD_ASSERT_NOW(a_event_kind, i_clk, i_rst_n, o_out_valid && o_kind == lmrd_pkg::KIND_EVENT, $onehot(o_status[3:0]) && o_item_index == 13'd0 && o_value == 32'd0)

    // Only events carry time, status and trace length.
    `LMRD_ASSERT_NOW(a_non_event, i_clk, i_rst_n, o_out_valid && o_kind != lmrd_pkg::KIND_EVENT, o_time_ps == 52'd0 && o_status == 6'd0 && o_trace_len == 15'd0)

    // Samples appear on trace pairs only.
    `LMRD_ASSERT_NOW(a_samples, i_clk, i_rst_n, o_out_valid && o_kind != lmrd_pkg::KIND_TRACE, o_sample_a == 15'd0 && o_sample_b == 15'd0)

    // A result that is not the last of its word is followed by a pad pair.
    `LMRD_ASSERT_NEXT(a_pad_follow, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last, o_out_valid && o_kind == lmrd_pkg::KIND_TRACE && o_sample_a == 15'd0 && o_sample_b == 15'd0)

endmodule

bind list_mode_record_decoder lmrd_checker u_lmrd_checker (.*);

`default_nettype wire
